// ----- design/mwc_srs_pkg.sv -----
// Shared types and constants for the multiply-with-carry state recovery block.
package mwc_srs_pkg;

    localparam int WORD_W      = 32;
    localparam int HALF_W      = 16;
    localparam int MULT_W      = 16;
    localparam int CFG_INDEX_W = 2;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_MULT_HIGH = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MULT_LOW  = 2'd1;

    localparam logic [MULT_W-1:0] MULT_HIGH_RESET = 16'd18273;
    localparam logic [MULT_W-1:0] MULT_LOW_RESET  = 16'd36969;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HIGH_MUL,
        ST_HIGH_ADV,
        ST_LOW_MUL,
        ST_LOW_ADV,
        ST_FINISH
    } state_t;

    // One issue to the shared multiply-add unit: mult * a + addend
    typedef struct packed {
        logic [MULT_W-1:0] mult;
        logic [HALF_W-1:0] a;
        logic [WORD_W-1:0] addend;
    } mac_op_t;

endpackage

// ----- design/mwc_state_recovery_search.sv -----
// Top level: recovers both multiply-with-carry states from two output words.
//
// Usage
//   Input channel: pulse start with first_word/second_word while busy is low;
//   the transfer happens at that clock edge and the words are latched.
//   Result channel: done is high for exactly one cycle, after the FINISH
//   state, with solved, recovered_state_high/low and next_word.
//   The receiver cannot stall; the result fields hold until the next result.
//   busy is high through the work states and a new start is taken in the
//   same cycle that done shows.
//   Work: each half needs two passes through the one shared multiply-add
//   unit (mult*h to find the carry, then one generator step for the third
//   output), so four issues, with the last result collected in ST_FINISH.
//   The first matching carry of the candidate search is (t - mult*h) mod
//   2^16, so the recovered state is {hi(mult*h) + borrow, t}.
//   Configuration: cfg_valid/cfg_ready/cfg_index/cfg_data, always ready;
//   index 0 sets multiplier_high, index 1 multiplier_low, others ignored.
//   Write only while idle.
//   Reset: asynchronous rst_n; multipliers return to 18273 and 36969, the
//   sequencer goes idle and no strobe is issued.
module mwc_state_recovery_search (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [mwc_srs_pkg::WORD_W-1:0]      first_word,
    input  logic [mwc_srs_pkg::WORD_W-1:0]      second_word,
    output logic                                done,
    output logic                                solved,
    output logic [mwc_srs_pkg::WORD_W-1:0]      recovered_state_high,
    output logic [mwc_srs_pkg::WORD_W-1:0]      recovered_state_low,
    output logic [mwc_srs_pkg::WORD_W-1:0]      next_word,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mwc_srs_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [mwc_srs_pkg::MULT_W-1:0]      cfg_data
);
    import mwc_srs_pkg::*;

    // Sequencer
    state_t state_reg;
    state_t state_next;

    // Configuration registers
    logic [MULT_W-1:0] mult_high_reg;
    logic [MULT_W-1:0] mult_low_reg;

    // Latched input words
    logic [WORD_W-1:0] word1_reg;
    logic [WORD_W-1:0] word2_reg;

    // Intermediate results
    logic [WORD_W-1:0] s0_reg;
    logic [WORD_W-1:0] s1_reg;
    logic [WORD_W-1:0] n0_reg;

    // Result registers
    logic              done_reg;
    logic              solved_reg;
    logic [WORD_W-1:0] state_high_reg;
    logic [WORD_W-1:0] state_low_reg;
    logic [WORD_W-1:0] next_word_reg;

    // Shared unit
    mac_op_t           mac_op;
    logic [WORD_W-1:0] mac_y;

    // Per-state control
    logic              accept;
    logic              cap_s0;
    logic              cap_n0;
    logic              cap_s1;
    logic              finish;

    logic [HALF_W-1:0] target;
    logic [HALF_W-1:0] state_upper;
    logic              borrow;

    assign accept    = start && (state_reg == ST_IDLE);
    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;

    // Target half of the second word for the half being solved
    assign target = (state_reg == ST_HIGH_ADV) ? word2_reg[WORD_W-1:HALF_W]
                                               : word2_reg[HALF_W-1:0];

    // mac_y holds mult*h here; adding the carry lands the low half on the
    // target and borrows into the upper half when the target is below it.
    assign borrow      = (target < mac_y[HALF_W-1:0]);
    assign state_upper = mac_y[WORD_W-1:HALF_W] + {{(HALF_W-1){1'b0}}, borrow};

    mwc_srs_mac u_mac (
        .clk (clk),
        .op  (mac_op),
        .y   (mac_y)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:     if (start) state_next = ST_HIGH_MUL;
            ST_HIGH_MUL: state_next = ST_HIGH_ADV;
            ST_HIGH_ADV: state_next = ST_LOW_MUL;
            ST_LOW_MUL:  state_next = ST_LOW_ADV;
            ST_LOW_ADV:  state_next = ST_FINISH;
            ST_FINISH:   state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // Unit issue and capture strobes
    always_comb
    begin
        mac_op.mult   = mult_high_reg;
        mac_op.a      = '0;
        mac_op.addend = '0;
        cap_s0        = 1'b0;
        cap_n0        = 1'b0;
        cap_s1        = 1'b0;
        finish        = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
            end
            ST_HIGH_MUL:
            begin
                mac_op.a = word1_reg[WORD_W-1:HALF_W];
            end
            ST_HIGH_ADV:
            begin
                // step the recovered state {state_upper, target}
                mac_op.a      = target;
                mac_op.addend = {{(WORD_W-HALF_W){1'b0}}, state_upper};
                cap_s0        = 1'b1;
            end
            ST_LOW_MUL:
            begin
                mac_op.mult = mult_low_reg;
                mac_op.a    = word1_reg[HALF_W-1:0];
                cap_n0      = 1'b1;
            end
            ST_LOW_ADV:
            begin
                mac_op.mult   = mult_low_reg;
                mac_op.a      = target;
                mac_op.addend = {{(WORD_W-HALF_W){1'b0}}, state_upper};
                cap_s1        = 1'b1;
            end
            ST_FINISH:
            begin
                finish = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mult_high_reg <= MULT_HIGH_RESET;
            mult_low_reg  <= MULT_LOW_RESET;
            done_reg      <= 1'b0;
            solved_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= finish;
            if (finish)
            begin
                solved_reg <= 1'b1;
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_MULT_HIGH)
                begin
                    mult_high_reg <= cfg_data;
                end
                else if (cfg_index == CFG_MULT_LOW)
                begin
                    mult_low_reg <= cfg_data;
                end
            end
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            word1_reg <= first_word;
            word2_reg <= second_word;
        end
        if (cap_s0)
        begin
            s0_reg <= {state_upper, target};
        end
        if (cap_n0)
        begin
            n0_reg <= mac_y;
        end
        if (cap_s1)
        begin
            s1_reg <= {state_upper, target};
        end
        if (finish)
        begin
            state_high_reg <= s0_reg;
            state_low_reg  <= s1_reg;
            next_word_reg  <= {n0_reg[HALF_W-1:0], mac_y[HALF_W-1:0]};
        end
    end

    assign done                 = done_reg;
    assign solved               = solved_reg;
    assign recovered_state_high = state_high_reg;
    assign recovered_state_low  = state_low_reg;
    assign next_word            = next_word_reg;

endmodule

// ----- design/mwc_srs_mac.sv -----
// Shared 16x16 multiply with 32-bit add, result registered.
module mwc_srs_mac (
    input  logic                          clk,
    input  mwc_srs_pkg::mac_op_t          op,
    output logic [mwc_srs_pkg::WORD_W-1:0] y
);
    import mwc_srs_pkg::*;

    logic [WORD_W-1:0] prod;
    logic [WORD_W-1:0] y_reg;
    logic [WORD_W-1:0] y_next;

    assign prod   = {{(WORD_W-MULT_W){1'b0}}, op.mult} * {{(WORD_W-HALF_W){1'b0}}, op.a};
    assign y_next = prod + op.addend;

    always_ff @(posedge clk)
    begin
        y_reg <= y_next;
    end

    assign y = y_reg;

endmodule

// ----- design/mwc_srs_checker.sv -----
// Port-level checks for the state recovery block, bound to the top level.
module mwc_srs_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done,
    input logic solved
);

    // accepted transfer starts work at once
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after accepted transfer");

    // result strobe lasts one cycle
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held longer than one cycle");

    // end of work always delivers a result
    a_fell_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy dropped without a result");

    // no result while still working, and solved is set with it
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy && solved)
        else $error("result shown while busy or unsolved");

endmodule

bind mwc_state_recovery_search mwc_srs_checker u_mwc_srs_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .solved (solved)
);
